[sv/qbld_pkg.sv]
package qbld_pkg;

    // Word width of the dividend halves, the divisor and the quotient.
    localparam int WORD_W = 32;

    // One non-restoring step is done per pipeline stage.
    localparam int STEP_COUNT = 32;

    // Everything one item carries from one step to the next.
    typedef struct packed {
        logic [WORD_W-1:0] acc;  // quotient bits gathered so far
        logic              t;    // pending quotient bit
        logic [WORD_W-1:0] lo;   // low dividend word, shifted left each step
        logic [WORD_W-1:0] hi;   // partial remainder
        logic              q;    // sense bit of the partial remainder
        logic              m;    // sign of the divisor
        logic [WORD_W-1:0] dv;   // divisor
    } stage_t;

endpackage

[sv/quad_by_long_nonrestoring_divide_top.sv]
// 64-by-32 non-restoring divider, one step of the division per pipeline stage.
//
// Input channel: dividend_low, dividend_high and divisor move as one beat on
// dividend_valid / dividend_ready. Output channel: quotient moves as one beat
// on quotient_valid / quotient_ready.
//
// An accepted input beat passes through all 32 stages before quotient_valid:
// each stage holds one 32-bit add/subtract step. Throughput is one
// beat per cycle while the receiver takes results.
//
// A reset clears the valid bit of every stage; the pipeline comes up empty
// and dividend_ready is high at once.
//
// When the receiver holds quotient_ready low with a result waiting, the whole
// pipeline freezes and dividend_ready drops in the same cycle, so no beat is
// lost or repeated. Empty stages are not squeezed out during a stall.
// A zero divisor or an overflowing quotient raises no flag; the raw bits of
// the step sequence are returned.
module quad_by_long_nonrestoring_divide_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dividend_valid,
    output logic        dividend_ready,
    input  logic [31:0] dividend_low,
    input  logic [31:0] dividend_high,
    input  logic [31:0] divisor,
    output logic        quotient_valid,
    input  logic        quotient_ready,
    output logic [31:0] quotient
);
    import qbld_pkg::*;

    logic                  en;
    logic [STEP_COUNT:0]   valid_chain;
    stage_t                data_chain [STEP_COUNT+1];
    stage_t                last_data;

    // The pipe advances whenever the last stage is empty or being taken.
    assign en             = !valid_chain[STEP_COUNT] || quotient_ready;
    assign dividend_ready = en;

    // Starting values of the step sequence.
    always_comb
    begin
        data_chain[0].acc = '0;
        data_chain[0].lo  = dividend_low;
        data_chain[0].hi  = dividend_high;
        data_chain[0].dv  = divisor;
        data_chain[0].q   = dividend_high[WORD_W-1];
        data_chain[0].m   = divisor[WORD_W-1];
        data_chain[0].t   = dividend_high[WORD_W-1] ^ divisor[WORD_W-1];
    end
    assign valid_chain[0] = dividend_valid;

    // The chain of step stages.
    genvar gi;
    generate
        for (gi = 0; gi < STEP_COUNT; gi++)
        begin : g_step
            qbld_stage u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (valid_chain[gi]),
                .in_data   (data_chain[gi]),
                .out_valid (valid_chain[gi+1]),
                .out_data  (data_chain[gi+1])
            );
        end
    endgenerate

    // The final shift brings in the last quotient bit.
    assign last_data      = data_chain[STEP_COUNT];
    assign quotient_valid = valid_chain[STEP_COUNT];
    assign quotient       = {last_data.acc[WORD_W-2:0], last_data.t};

    // A stalled result freezes every stage's valid bit.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (quotient_valid && !quotient_ready) |=> $stable(valid_chain[STEP_COUNT:1]))
        else $error("pipeline moved during an output stall");

    // An accepted beat shows up as a valid first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (dividend_valid && dividend_ready) |=> valid_chain[1])
        else $error("accepted beat did not enter the first stage");

    // The divisor sign travels unchanged with its divisor.
    a_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
        quotient_valid |-> (last_data.m == last_data.dv[WORD_W-1]))
        else $error("divisor sign lost along the pipeline");

    // The low word is fully shifted out by the end of the steps.
    a_low_drained: assert property (@(posedge clk) disable iff (!rst_n)
        quotient_valid |-> (last_data.lo == '0))
        else $error("low dividend word not drained");

endmodule

[sv/qbld_stage.sv]
module qbld_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  qbld_pkg::stage_t in_data,
    output logic             out_valid,
    output qbld_pkg::stage_t out_data
);
    import qbld_pkg::*;

    logic              valid_reg;
    stage_t            data_reg;
    stage_t            data_next;
    logic [WORD_W-1:0] shifted;
    logic [WORD_W:0]   diff;
    logic [WORD_W:0]   sum;
    logic              cy;
    logic              q_next;

    // One step: shift the remainder in, then add or subtract the divisor.
    always_comb
    begin
        shifted = {in_data.hi[WORD_W-2:0], in_data.lo[WORD_W-1]};
        diff    = {1'b0, shifted} - {1'b0, in_data.dv};
        sum     = {1'b0, shifted} + {1'b0, in_data.dv};

        data_next     = in_data;
        data_next.acc = {in_data.acc[WORD_W-2:0], in_data.t};
        data_next.lo  = {in_data.lo[WORD_W-2:0], 1'b0};

        if (in_data.q == in_data.m)
        begin
            data_next.hi = diff[WORD_W-1:0];
            cy           = diff[WORD_W];
        end
        else
        begin
            data_next.hi = sum[WORD_W-1:0];
            cy           = sum[WORD_W];
        end

        q_next      = in_data.hi[WORD_W-1] ^ cy ^ in_data.m;
        data_next.q = q_next;
        data_next.t = (q_next == in_data.m);
    end

    // The valid bit is control state and is reset; the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[test/quad_by_long_nonrestoring_divide_top_tb.sv]
`timescale 1ns / 100ps

// Tracks the quotients still owed by the divider and checks each returned beat.
class quotient_scoreboard;
    logic [31:0] expected_quotients[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // Bit-exact 32-step non-restoring division of {hi, lo} by dv.
    function automatic logic [31:0] nonrestoring_quotient(logic [31:0] lo, logic [31:0] hi,
                                                          logic [31:0] dv);
        logic        sense;
        logic        dv_sign;
        logic        qbit;
        logic        top;
        logic        carry;
        logic [31:0] acc;
        logic [31:0] shifted;
        logic [32:0] wide;
        sense   = hi[31];
        dv_sign = dv[31];
        qbit    = sense ^ dv_sign;
        acc     = '0;
        for (int k = 0; k < 32; k++)
        begin
            acc     = {acc[30:0], qbit};
            qbit    = lo[31];
            lo      = lo << 1;
            top     = hi[31];
            shifted = {hi[30:0], qbit};
            // Subtract when the remainder and divisor agree in sense, else add back.
            if (sense == dv_sign)
                wide = {1'b0, shifted} - {1'b0, dv};
            else
                wide = {1'b0, shifted} + {1'b0, dv};
            hi    = wide[31:0];
            carry = wide[32];
            sense = top ^ carry ^ dv_sign;
            qbit  = (sense == dv_sign);
        end
        return {acc[30:0], qbit};
    endfunction

    task report_mismatch(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    // An input beat was accepted: queue the quotient it must produce.
    function void note_dividend(logic [31:0] lo, logic [31:0] hi, logic [31:0] dv);
        expected_quotients.push_back(nonrestoring_quotient(lo, hi, dv));
    endfunction

    // A quotient beat was accepted: compare it with the oldest expectation.
    task check_quotient(logic [31:0] got);
        logic [31:0] want;
        if (expected_quotients.size() == 0)
        begin
            report_mismatch($sformatf("quotient %h arrived with nothing expected", got));
        end
        else
        begin
            want = expected_quotients.pop_front();
            if (got !== want)
                report_mismatch($sformatf("quotient %h, expected %h", got, want));
        end
    endtask

    function int pending();
        return expected_quotients.size();
    endfunction
endclass

module quad_by_long_nonrestoring_divide_top_tb;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 530;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        dividend_valid = 1'b0;
    logic        dividend_ready;
    logic [31:0] dividend_low = '0;
    logic [31:0] dividend_high = '0;
    logic [31:0] divisor = '0;
    logic        quotient_valid;
    logic        quotient_ready = 1'b0;
    logic [31:0] quotient;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    quotient_scoreboard sb = new();

    quad_by_long_nonrestoring_divide_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .dividend_valid (dividend_valid),
        .dividend_ready (dividend_ready),
        .dividend_low   (dividend_low),
        .dividend_high  (dividend_high),
        .divisor        (divisor),
        .quotient_valid (quotient_valid),
        .quotient_ready (quotient_ready),
        .quotient       (quotient)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver stalls at random, decided once per cycle on the falling edge.
    always @(negedge clk)
    begin
        quotient_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every quotient beat as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && quotient_valid && quotient_ready)
            sb.check_quotient(quotient);
    end

    // Watchdog: give up after a long run of cycles with no beat on either side.
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((dividend_valid && dividend_ready) || (quotient_valid && quotient_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Offer one dividend beat, idling first at random, and return once it is taken.
    task send_dividend(logic [31:0] lo, logic [31:0] hi, logic [31:0] dv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            dividend_valid <= 1'b0;
            @(negedge clk);
        end
        dividend_valid <= 1'b1;
        dividend_low   <= lo;
        dividend_high  <= hi;
        divisor        <= dv;
        do
            @(posedge clk);
        while (!(dividend_valid && dividend_ready));
        sb.note_dividend(lo, hi, dv);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every owed quotient has come back.
    task wait_for_drain();
        dividend_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Word biased toward edge values, small magnitudes and single bits.
    function automatic logic [31:0] random_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return 32'h1 << $urandom_range(31);
            5: return $urandom_range(255);
            6: return ~($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    // Half are in-range divisions (remainder smaller than divisor), with signs
    // flipped at random; the rest are edge-heavy or fully random words.
    task run_random_phase(int count);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] dv;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(3))
                0:
                begin
                    lo = random_word();
                    hi = random_word();
                    dv = random_word();
                end
                3:
                begin
                    lo = $urandom;
                    hi = $urandom;
                    dv = $urandom;
                end
                default:
                begin
                    dv = ($urandom_range(1) != 0) ? $urandom : $urandom_range(65535);
                    if (dv == 0)
                        dv = 1;
                    hi = $urandom % dv;
                    lo = $urandom;
                    if ($urandom_range(1) != 0)
                        hi = ~hi;
                    if ($urandom_range(1) != 0)
                        dv = -dv;
                end
            endcase
            send_dividend(lo, hi, dv);
        end
    endtask

    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats: extremes, zero divisor, overflow and every sign mix.
        send_dividend(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        send_dividend(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_dividend(32'h1234_5678, 32'h0000_0042, 32'h0000_0000);
        send_dividend(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        send_dividend(32'h0000_0064, 32'h0000_0000, 32'h0000_0007);
        send_dividend(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_dividend(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
        send_dividend(32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
        send_dividend(32'hDEAD_BEEF, 32'h4000_0000, 32'h1000_0000);
        send_dividend(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003);
        send_dividend(32'h0000_0009, 32'h0000_0000, 32'hFFFF_FFFD);
        send_dividend(32'hFFFF_FFF7, 32'hFFFF_FFFF, 32'hFFFF_FFFD);
        send_dividend(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_dividend(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_dividend(32'h8000_0000, 32'h0000_0001, 32'h0000_0002);
        send_dividend(32'h7FFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0001);
        wait_for_drain();

        // Slow sender against a mostly stalled receiver.
        send_idle_pct = 28;
        recv_idle_pct = 84;
        run_random_phase(PHASE_ITEMS);
        wait_for_drain();

        // Mostly idle sender against a mostly ready receiver.
        send_idle_pct = 84;
        recv_idle_pct = 28;
        run_random_phase(PHASE_ITEMS);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);

        // Drain the pipeline, then allow for its latency.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d quotients never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
